[design/ssp_pkg.sv]
// shared constants, codes and types for the shortest paths core
package ssp_pkg;

  localparam int MAX_VERTICES_DEF = 16;
  localparam int WEIGHT_BITS_DEF  = 16;
  localparam int DIST_BITS_DEF    = 20;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NEG     = 2'd1;
  localparam logic [1:0] ST_BAD_SRC = 2'd2;
  localparam logic [1:0] ST_WRITTEN = 2'd3;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_RUN   = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_ROUND,
    S_EVAL,
    S_OUT
  } state_t;

  // common control broadcast to every cell of the row
  typedef struct packed {
    logic init;
    logic begin_round;
    logic shift;
    logic acc;
    logic commit;
  } cell_ctl_t;

endpackage

[design/ssp_if.sv]
// item channels: run/edge requests in, per-vertex results out
interface ssp_req_if;
  logic               valid;
  logic               ready;
  logic               mode;
  logic [3:0]         from_vertex;
  logic [3:0]         to_vertex;
  logic signed [15:0] edge_weight;
  logic               edge_present;
  logic [3:0]         source_vertex;

  modport source (output valid, mode, from_vertex, to_vertex, edge_weight,
                  edge_present, source_vertex, input ready);
  modport sink (input valid, mode, from_vertex, to_vertex, edge_weight,
                edge_present, source_vertex, output ready);
endinterface

interface ssp_rsp_if;
  logic               valid;
  logic               ready;
  logic [3:0]         vertex;
  logic signed [19:0] distance;
  logic               reached;
  logic [1:0]         status;
  logic               last;

  modport source (output valid, vertex, distance, reached, status, last,
                  input ready);
  modport sink (input valid, vertex, distance, reached, status, last,
                output ready);
endinterface

[design/ssp_ram.sv]
// generic single write, single read ram with registered read data
module ssp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[design/ssp_cell.sv]
// one vertex cell: its weight column, distance state and a ring token stage
module ssp_cell #(
  parameter int MAX_VERTICES = 16,
  parameter int WEIGHT_BITS  = 16,
  parameter int DIST_BITS    = 20,
  parameter int CELL_ID      = 0,
  parameter int CW           = 5
) (
  input  logic                            clk,
  input  logic                            rst,
  input  ssp_pkg::cell_ctl_t              ctl,
  input  logic [CW-1:0]                   n_eff,
  input  logic [$clog2(MAX_VERTICES)-1:0] src,
  input  logic                            wr_en,
  input  logic [$clog2(MAX_VERTICES)-1:0] wr_row,
  input  logic [WEIGHT_BITS-1:0]          wr_weight,
  input  logic                            wr_present,
  input  logic signed [DIST_BITS-1:0]     nbr_d,
  input  logic                            nbr_r,
  input  logic [$clog2(MAX_VERTICES)-1:0] nbr_i,
  output logic signed [DIST_BITS-1:0]     tok_d,
  output logic                            tok_r,
  output logic [$clog2(MAX_VERTICES)-1:0] tok_i,
  output logic signed [DIST_BITS-1:0]     now_d,
  output logic                            now_r,
  output logic                            changed
);
  import ssp_pkg::*;

  localparam int VW   = $clog2(MAX_VERTICES);
  localparam int SUMW = ((DIST_BITS > WEIGHT_BITS) ? DIST_BITS : WEIGHT_BITS) + 1;
  localparam logic signed [SUMW-1:0] SMAX =
    {{(SUMW - DIST_BITS + 1){1'b0}}, {(DIST_BITS - 1){1'b1}}};
  localparam logic signed [SUMW-1:0] SMIN = ~SMAX;
  localparam logic [VW-1:0] MY_ID = VW'(CELL_ID);

  logic [MAX_VERTICES-1:0]        ev;
  logic signed [DIST_BITS-1:0]    best_d;
  logic                           best_r;
  logic signed [DIST_BITS-1:0]    hold_d;
  logic                           hold_r;
  logic [VW-1:0]                  hold_i;
  logic                           hold_e;
  logic [WEIGHT_BITS-1:0]         rdata;
  logic                           active;
  logic signed [SUMW-1:0]         sum;
  logic signed [DIST_BITS-1:0]    cand;
  logic                           take;

  ssp_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(MAX_VERTICES)) u_col (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_row),
    .wdata (wr_weight),
    .raddr (tok_i),
    .rdata (rdata)
  );

  assign active = (CW'(CELL_ID) < n_eff);

  // saturating min-plus candidate from the token seen last cycle
  always_comb begin
    sum = {{(SUMW - DIST_BITS){hold_d[DIST_BITS-1]}}, hold_d}
        + {{(SUMW - WEIGHT_BITS){rdata[WEIGHT_BITS-1]}}, rdata};
    if (sum > SMAX) begin
      cand = SMAX[DIST_BITS-1:0];
    end else if (sum < SMIN) begin
      cand = SMIN[DIST_BITS-1:0];
    end else begin
      cand = sum[DIST_BITS-1:0];
    end
    take = active && hold_r && hold_e && (hold_i != MY_ID)
        && (!best_r || (cand < best_d));
  end

  assign changed = active && ((best_r != now_r) || (best_d != now_d));

  always_ff @(posedge clk) begin
    if (rst) begin
      ev    <= '0;
      now_r <= 1'b0;
      now_d <= '0;
    end else begin
      if (wr_en) begin
        ev[wr_row] <= wr_present;
      end
      if (ctl.init) begin
        now_d <= '0;
        now_r <= (src == MY_ID);
      end else if (ctl.commit) begin
        now_d <= best_d;
        now_r <= best_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.begin_round) begin
      tok_d  <= now_d;
      tok_r  <= now_r;
      tok_i  <= MY_ID;
      best_d <= now_r ? now_d : '0;
      best_r <= now_r;
    end else begin
      if (ctl.shift) begin
        hold_d <= tok_d;
        hold_r <= tok_r;
        hold_i <= tok_i;
        hold_e <= ev[tok_i];
        tok_d  <= nbr_d;
        tok_r  <= nbr_r;
        tok_i  <= nbr_i;
      end
      if (ctl.acc && take) begin
        best_d <= cand;
        best_r <= 1'b1;
      end
    end
  end
endmodule

[design/single_source_shortest_paths_core.sv]
// top level of the shortest paths core: control, cell ring and result register
//
// channel | dir | payload                                        | handshake
// req     | in  | mode, from/to vertex, edge weight/present, src | valid/ready
// rsp     | out | vertex, distance, reached, status, last        | valid/ready
// cfg     | in  | vertex_count (5 bits)                          | cfg_we only
//
// an edge write gives one result item
// a run takes at most n rounds, each one full turn of the cell ring, then gives
// one result item per vertex in use, or a single item if a negative cycle is found
// synchronous reset clears the edge valid bits, distances and control
// a stalled result holds the core; new items wait until the result register empties
module single_source_shortest_paths_core
  import ssp_pkg::*;
#(
  parameter int MAX_VERTICES = ssp_pkg::MAX_VERTICES_DEF,
  parameter int WEIGHT_BITS  = ssp_pkg::WEIGHT_BITS_DEF,
  parameter int DIST_BITS    = ssp_pkg::DIST_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [4:0] cfg_data,
  ssp_req_if.sink    req,
  ssp_rsp_if.source  rsp
);
  localparam int VW  = $clog2(MAX_VERTICES);
  localparam int IW  = (VW > 4) ? VW : 4;
  localparam int CW0 = $clog2(MAX_VERTICES + 1);
  localparam int CW  = (CW0 > 5) ? CW0 : 5;
  localparam int STW = $clog2(MAX_VERTICES + 1);
  localparam int WW2 = (WEIGHT_BITS > 16) ? WEIGHT_BITS : 16;
  localparam int DW2 = (DIST_BITS > 20) ? DIST_BITS : 20;
  localparam logic [CW-1:0]  NMAX = CW'(MAX_VERTICES);
  localparam logic [STW-1:0] STEPS = STW'(MAX_VERTICES);
  localparam logic [IW:0]    VLIM = (IW+1)'(MAX_VERTICES);

  // configuration
  logic [4:0]    vcount;
  logic [CW-1:0] n_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      vcount <= 5'd16;
    end else if (cfg_we) begin
      vcount <= cfg_data;
    end
  end

  assign n_eff = (CW'(vcount) > NMAX) ? NMAX : CW'(vcount);

  // control state
  state_t         state, state_next;
  logic [STW-1:0] step, step_next;
  logic [CW-1:0]  rounds, rounds_next;
  logic           check, check_next;
  logic [VW-1:0]  out_idx, out_idx_next;
  cell_ctl_t      ctl;

  // result register
  logic          o_valid;
  logic          o_load;
  logic [3:0]    o_vertex_next;
  logic [19:0]   o_dist_next;
  logic          o_reached_next;
  logic [1:0]    o_status_next;
  logic          o_last_next;

  // request decode
  logic              accept;
  logic [IW-1:0]     from_ext, to_ext, src_ext;
  logic              in_range;
  logic              src_ok;
  logic [VW-1:0]     src_v;
  logic [WW2-1:0]    w_wide;
  logic [MAX_VERTICES-1:0] chg;
  logic              any_change;

  // cell ring
  logic signed [DIST_BITS-1:0] tok_d [MAX_VERTICES];
  logic                        tok_r [MAX_VERTICES];
  logic [VW-1:0]               tok_i [MAX_VERTICES];
  logic signed [DIST_BITS-1:0] now_d [MAX_VERTICES];
  logic                        now_r [MAX_VERTICES];

  // output formatting
  logic [DIST_BITS-1:0] sel_d;
  logic [DW2-1:0]       d_wide;
  logic [IW-1:0]        idx_wide;

  assign accept   = req.valid && req.ready;
  assign from_ext = IW'(req.from_vertex);
  assign to_ext   = IW'(req.to_vertex);
  assign src_ext  = IW'(req.source_vertex);
  // one extra bit so the vertex limit itself is representable
  assign in_range = ({1'b0, from_ext} < VLIM) && ({1'b0, to_ext} < VLIM);
  assign src_ok   = (CW'(src_ext) < n_eff);
  assign src_v    = src_ext[VW-1:0];
  assign w_wide   = WW2'($unsigned(req.edge_weight));
  assign any_change = |chg;

  for (genvar j = 0; j < MAX_VERTICES; j++) begin : g_cell
    localparam int NB = (j + 1) % MAX_VERTICES;
    logic wr_en_j;

    // a cell owns column j, so it takes writes whose head is j
    assign wr_en_j = accept && (req.mode == MODE_WRITE) && in_range
                  && (to_ext[VW-1:0] == VW'(j));

    ssp_cell #(
      .MAX_VERTICES (MAX_VERTICES),
      .WEIGHT_BITS  (WEIGHT_BITS),
      .DIST_BITS    (DIST_BITS),
      .CELL_ID      (j),
      .CW           (CW)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .n_eff      (n_eff),
      .src        (src_v),
      .wr_en      (wr_en_j),
      .wr_row     (from_ext[VW-1:0]),
      .wr_weight  (w_wide[WEIGHT_BITS-1:0]),
      .wr_present (req.edge_present),
      .nbr_d      (tok_d[NB]),
      .nbr_r      (tok_r[NB]),
      .nbr_i      (tok_i[NB]),
      .tok_d      (tok_d[j]),
      .tok_r      (tok_r[j]),
      .tok_i      (tok_i[j]),
      .now_d      (now_d[j]),
      .now_r      (now_r[j]),
      .changed    (chg[j])
    );
  end

  // per-vertex result fields, unreached reads as distance zero
  always_comb begin
    sel_d    = now_r[out_idx] ? now_d[out_idx] : '0;
    d_wide   = DW2'(sel_d);
    idx_wide = IW'(out_idx);
  end

  // next state and control
  always_comb begin
    state_next     = state;
    step_next      = step;
    rounds_next    = rounds;
    check_next     = check;
    out_idx_next   = out_idx;
    ctl            = '0;
    o_load         = 1'b0;
    o_vertex_next  = '0;
    o_dist_next    = '0;
    o_reached_next = 1'b0;
    o_status_next  = ST_OK;
    o_last_next    = 1'b1;
    req.ready      = (state == S_IDLE) && !o_valid;

    case (state)
      S_IDLE: begin
        if (accept) begin
          if (req.mode == MODE_WRITE) begin
            o_load        = 1'b1;
            o_status_next = ST_WRITTEN;
          end else if (!src_ok) begin
            o_load        = 1'b1;
            o_status_next = ST_BAD_SRC;
            o_vertex_next = req.source_vertex;
          end else begin
            ctl.init    = 1'b1;
            rounds_next = '0;
            // a single vertex goes straight to the check round
            check_next  = (n_eff == CW'(1));
            state_next  = S_START;
          end
        end
      end
      S_START: begin
        ctl.begin_round = 1'b1;
        step_next       = '0;
        state_next      = S_ROUND;
      end
      S_ROUND: begin
        // tokens make one full turn of the ring, accumulation trails the shift
        ctl.shift = (step != STEPS);
        ctl.acc   = (step != '0);
        step_next = step + STW'(1);
        if (step == STEPS) begin
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        if (check) begin
          if (any_change) begin
            o_load        = 1'b1;
            o_status_next = ST_NEG;
            state_next    = S_IDLE;
          end else begin
            out_idx_next = '0;
            state_next   = S_OUT;
          end
        end else if (any_change) begin
          ctl.commit  = 1'b1;
          rounds_next = rounds + CW'(1);
          if ((rounds + CW'(1)) >= (n_eff - CW'(1))) begin
            check_next = 1'b1;
          end
          state_next = S_START;
        end else begin
          out_idx_next = '0;
          state_next   = S_OUT;
        end
      end
      S_OUT: begin
        if (!o_valid || rsp.ready) begin
          o_load         = 1'b1;
          o_vertex_next  = idx_wide[3:0];
          o_dist_next    = d_wide[19:0];
          o_reached_next = now_r[out_idx];
          o_status_next  = ST_OK;
          o_last_next    = (CW'(out_idx) == (n_eff - CW'(1)));
          out_idx_next   = out_idx + VW'(1);
          if (o_last_next) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      step    <= '0;
      rounds  <= '0;
      check   <= 1'b0;
      out_idx <= '0;
      o_valid <= 1'b0;
    end else begin
      state   <= state_next;
      step    <= step_next;
      rounds  <= rounds_next;
      check   <= check_next;
      out_idx <= out_idx_next;
      if (o_load) begin
        o_valid <= 1'b1;
      end else if (rsp.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (o_load) begin
      rsp.vertex   <= o_vertex_next;
      rsp.distance <= o_dist_next;
      rsp.reached  <= o_reached_next;
      rsp.status   <= o_status_next;
      rsp.last     <= o_last_next;
    end
  end

  assign rsp.valid = o_valid;

  // a new item is only taken with the core and result register empty
  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    accept |-> (state == S_IDLE) && !o_valid)
    else $error("item accepted while busy");

  // the ring never rotates past one full turn
  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROUND) |-> (step <= STEPS))
    else $error("round step overran");

  // evaluation always leads to another round, the result phase or idle
  a_eval_exit: assert property (@(posedge clk) disable iff (rst)
    (state == S_EVAL) |=> (state == S_START) || (state == S_OUT) || (state == S_IDLE))
    else $error("bad exit from evaluation");

  // a run's result stream ends exactly on the last vertex in use
  a_last_vertex: assert property (@(posedge clk) disable iff (rst)
    o_load && (state == S_OUT) && o_last_next |-> (CW'(out_idx) == n_eff - CW'(1)))
    else $error("last flag off the final vertex");
endmodule
